// File: design/frgcd_pkg.sv
package frgcd_pkg;

  // Sequencer states of the fraction reducer.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SCALE,
    S_DIV_NUM,
    S_DIV_DEN,
    S_OUT
  } frgcd_state_t;

endpackage

// File: design/frgcd_if.sv
interface frgcd_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frgcd_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] reduced_numerator;
  logic signed [DATA_WIDTH-1:0] reduced_denominator;
  logic        [DATA_WIDTH-1:0] common_divisor;
  logic                         zero_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output common_divisor, output zero_denominator, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input common_divisor, input zero_denominator, output ready);
endinterface

// File: design/frgcd_divider.sv
module frgcd_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] dsr_r;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (!diff[DATA_WIDTH]) begin
        rem_r <= diff[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/fraction_reducer_gcd.sv
// Channel   Port      Direction  Beat contents
// input     in_chan   sink       numerator, denominator
// result    out_chan  source     reduced_numerator, reduced_denominator,
//                                common_divisor, zero_denominator
//
// One beat in gives one beat out. An item is loaded, then runs binary GCD steps
// (one compare/subtract or shift per cycle), puts back one common factor of two
// per cycle to rebuild the divisor, starts the divider, makes two passes through
// the shared bit-serial divider, and offers the result until it is taken.
// A zero denominator skips all of that and is offered the cycle after it loads.
// Reset is synchronous and active low; in_chan.ready is high only while idle,
// and a result holds on out_chan until it is taken.
module fraction_reducer_gcd #(
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  frgcd_in_if.sink  in_chan,
  frgcd_out_if.source out_chan
);

  import frgcd_pkg::*;

  localparam int KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  frgcd_state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [DATA_WIDTH-1:0] g_r, g_nxt;
  logic [DATA_WIDTH-1:0] mag_num_r, mag_num_nxt;
  logic [DATA_WIDTH-1:0] mag_den_r, mag_den_nxt;
  logic                  num_neg_r, num_neg_nxt;
  logic                  den_neg_r, den_neg_nxt;
  logic [DATA_WIDTH-1:0] res_num_r, res_num_nxt;
  logic [DATA_WIDTH-1:0] res_den_r, res_den_nxt;
  logic                  zero_r, zero_nxt;

  logic [DATA_WIDTH-1:0] in_num_mag;
  logic [DATA_WIDTH-1:0] in_den_mag;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quotient;

  // Magnitudes are kept unsigned, so the most negative value fits.
  assign in_num_mag = in_chan.numerator[DATA_WIDTH-1] ?
                      DATA_WIDTH'(-in_chan.numerator) : DATA_WIDTH'(in_chan.numerator);
  assign in_den_mag = in_chan.denominator[DATA_WIDTH-1] ?
                      DATA_WIDTH'(-in_chan.denominator) : DATA_WIDTH'(in_chan.denominator);

  frgcd_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    g_r       <= g_nxt;
    mag_num_r <= mag_num_nxt;
    mag_den_r <= mag_den_nxt;
    num_neg_r <= num_neg_nxt;
    den_neg_r <= den_neg_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    zero_r    <= zero_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    g_nxt        = g_r;
    mag_num_nxt  = mag_num_r;
    mag_den_nxt  = mag_den_r;
    num_neg_nxt  = num_neg_r;
    den_neg_nxt  = den_neg_r;
    res_num_nxt  = res_num_r;
    res_den_nxt  = res_den_r;
    zero_nxt     = zero_r;
    div_start    = 1'b0;
    div_dividend = mag_num_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          a_nxt       = in_num_mag;
          b_nxt       = in_den_mag;
          k_nxt       = '0;
          mag_num_nxt = in_num_mag;
          mag_den_nxt = in_den_mag;
          num_neg_nxt = in_chan.numerator[DATA_WIDTH-1];
          den_neg_nxt = in_chan.denominator[DATA_WIDTH-1];
          if (in_chan.denominator == '0) begin
            zero_nxt    = 1'b1;
            g_nxt       = '0;
            res_num_nxt = '0;
            res_den_nxt = '0;
            state_nxt   = S_OUT;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = S_GCD;
          end
        end
      end

      // Binary GCD: b is never zero here, and a reaches zero only if it
      // started there.
      S_GCD: begin
        if (a_r == b_r) begin
          g_nxt     = a_r;
          state_nxt = S_SCALE;
        end else if (a_r == '0) begin
          g_nxt     = b_r;
          state_nxt = S_SCALE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end

      // Put back the common factors of two, one per cycle.
      S_SCALE: begin
        if (k_r == '0) begin
          div_start    = 1'b1;
          div_dividend = mag_num_r;
          state_nxt    = S_DIV_NUM;
        end else begin
          g_nxt = g_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end

      S_DIV_NUM: begin
        if (div_done) begin
          res_num_nxt  = num_neg_r ? DATA_WIDTH'(-div_quotient) : div_quotient;
          div_start    = 1'b1;
          div_dividend = mag_den_r;
          state_nxt    = S_DIV_DEN;
        end
      end

      S_DIV_DEN: begin
        if (div_done) begin
          res_den_nxt = den_neg_r ? DATA_WIDTH'(-div_quotient) : div_quotient;
          state_nxt   = S_OUT;
        end
      end

      S_OUT: begin
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_chan.ready                = (state_r == S_IDLE);
  assign out_chan.valid               = (state_r == S_OUT);
  assign out_chan.reduced_numerator   = res_num_r;
  assign out_chan.reduced_denominator = res_den_r;
  assign out_chan.common_divisor      = g_r;
  assign out_chan.zero_denominator    = zero_r;

`ifndef SYNTHESIS
  a_zero_den_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.zero_denominator |->
      out_chan.reduced_numerator == '0 && out_chan.reduced_denominator == '0 &&
      out_chan.common_divisor == '0)
    else $error("zero denominator result carries nonzero fields");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.zero_denominator |-> out_chan.common_divisor != '0)
    else $error("common divisor is zero on a valid fraction");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input taken while a result is pending");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_NUM || state_r == S_DIV_DEN)
    else $error("divider finished outside a division step");

  a_gcd_odd_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD && $past(state_r) == S_GCD && k_r != $past(k_r) |->
      $past(!a_r[0] && !b_r[0]))
    else $error("power of two counted without both operands even");
`endif

endmodule
